[src/infix_to_postfix_converter_defines.svh]
// Assertion helpers for the infix to postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define ITP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Same-cycle implication.
`define ITP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[src/itp_pkg.sv]
package itp_pkg;

    // Operator stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Characters with a meaning of their own
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_CLOSE = 2'd0;
    localparam logic [1:0] ERR_OPEN  = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;

    // Command handed from front to back
    typedef enum logic [2:0] {
        CMD_EMIT,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_OP,
        CMD_END
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [7:0]  ch;
        logic [1:0]  prec;
    } cmd_t;

    // Stack status seen by the top level
    typedef struct packed {
        logic [CNT_W-1:0] depth;
        logic             latched;
    } stk_status_t;

    // Operator precedence, everything else is zero
    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            p = 2'd2;
        end else if (c == CH_CARET) begin
            p = 2'd3;
        end
        return p;
    endfunction

endpackage

[src/infix_to_postfix_converter.sv]
// Channel   Ports                                               Direction
// input     s_valid s_ready s_char_in s_is_end                  in
// result    m_valid m_ready m_char_out m_kind m_error_code m_last  out
//
// The back end does one stack step per cycle while no result is stalled:
// an operand, push or paren drop is one step, each operator popped and
// emitted one more. An end item pops the operators above any open paren
// (none once an error is latched), then gives its done or error
// result. A two-entry command queue parts the input side from the stack
// engine. aresetn is synchronous; it clears queue, stack and error latch.
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_is_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_out,
    output logic [1:0] m_kind,
    output logic [1:0] m_error_code,
    output logic       m_last
);
    import itp_pkg::*;

    logic        cmd_valid;
    cmd_t        cmd;
    logic        cmd_pop;
    stk_status_t stk_st;
    logic        res_latching;
    logic        res_closing;
    logic        stk_idle;

    itp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .s_is_end  (s_is_end),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    itp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_out   (m_char_out),
        .m_kind       (m_kind),
        .m_error_code (m_error_code),
        .m_last       (m_last),
        .stk_status   (stk_st)
    );

    // Result classes used by the checks
    assign res_latching = m_valid && m_kind == KIND_ERR && m_error_code != ERR_OPEN;
    assign res_closing  = m_valid && (m_kind == KIND_DONE ||
                                      (m_kind == KIND_ERR && m_error_code == ERR_OPEN));
    assign stk_idle     = !stk_st.latched && (stk_st.depth == '0);

    // Checks
    `ITP_ASSERT_ALWAYS(a_depth_range, stk_st.depth <= CNT_W'(STACK_DEPTH), "stack depth overrun")
    `ITP_ASSERT_IMPL(a_status_last, m_valid && m_kind != KIND_CHAR, m_last, "status not last")
    `ITP_ASSERT_IMPL(a_err_latched, res_latching, stk_st.latched, "error not latched")
    `ITP_ASSERT_IMPL(a_end_clears, res_closing, stk_idle, "end did not clear")

endmodule

[src/itp_front.sv]
module itp_front (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_char_in,
    input  logic         s_is_end,
    output logic         cmd_valid,
    output itp_pkg::cmd_t cmd,
    input  logic         cmd_pop
);
    import itp_pkg::*;

    cmd_t        q_mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  q_count_reg, q_count_next;

    cmd_t        cls;
    logic        is_ws;
    logic        is_operand;
    logic        push;

    // Classify the incoming character
    always_comb begin
        is_ws = (s_char_in == CH_SPACE) || (s_char_in >= CH_TAB && s_char_in <= CH_CR);
        is_operand = (s_char_in >= 8'h30 && s_char_in <= 8'h39) ||
                     (s_char_in >= 8'h41 && s_char_in <= 8'h5A) ||
                     (s_char_in >= 8'h61 && s_char_in <= 8'h7A);
        cls.ch   = s_char_in;
        cls.prec = prec_of(s_char_in);
        if (s_is_end) begin
            cls.op = CMD_END;
        end else if (is_operand) begin
            cls.op = CMD_EMIT;
        end else if (s_char_in == CH_LPAREN) begin
            cls.op = CMD_OPEN;
        end else if (s_char_in == CH_RPAREN) begin
            cls.op = CMD_CLOSE;
        end else begin
            cls.op = CMD_OP;
        end
    end

    // Two-entry command queue; whitespace is dropped here
    assign s_ready   = (q_count_reg != 2'd2);
    assign push      = s_valid && s_ready && (s_is_end || !is_ws);
    assign cmd_valid = (q_count_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next  = wr_ptr_reg ^ push;
        rd_ptr_next  = rd_ptr_reg ^ cmd_pop;
        q_count_next = q_count_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            q_count_reg <= 2'd0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

[src/itp_back.sv]
module itp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  itp_pkg::cmd_t       cmd,
    output logic                cmd_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_char_out,
    output logic [1:0]          m_kind,
    output logic [1:0]          m_error_code,
    output logic                m_last,
    output itp_pkg::stk_status_t stk_status
);
    import itp_pkg::*;

    // Stack: top in a register, the rest in memory, next-below prefetched
    logic [7:0]       stk_mem [STACK_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       top_reg, top_next;
    logic [7:0]       below_reg;
    logic             latched_reg, latched_next;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       char_reg;
    logic [1:0]       kind_reg;
    logic [1:0]       code_reg;
    logic             last_reg;

    logic             load;
    logic [7:0]       o_char;
    logic [1:0]       o_kind;
    logic [1:0]       o_code;
    logic             o_last;

    logic             we;
    logic [ADDR_W-1:0] wa;
    logic [7:0]       wd;
    logic [CNT_W-1:0] rd_idx;
    logic [ADDR_W-1:0] ra;
    logic [CNT_W-1:0] wr_idx;

    logic             go;
    logic             cnt_nz;
    logic             cnt_ge2;
    logic             full;
    logic [1:0]       top_prec;
    logic [1:0]       below_prec;

    assign go         = cmd_valid && (!m_valid_reg || m_ready);
    assign cnt_nz     = (cnt_reg != '0);
    assign cnt_ge2    = (cnt_reg >= CNT_W'(2));
    assign full       = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign top_prec   = prec_of(top_reg);
    assign below_prec = prec_of(below_reg);
    assign wr_idx     = cnt_reg - CNT_W'(1);

    // One step of the shunting-yard sequencer per cycle, unless the result is stalled
    always_comb begin
        cnt_next     = cnt_reg;
        top_next     = top_reg;
        latched_next = latched_reg;
        cmd_pop      = 1'b0;
        load         = 1'b0;
        o_char       = 8'd0;
        o_kind       = KIND_CHAR;
        o_code       = ERR_CLOSE;
        o_last       = 1'b0;
        we           = 1'b0;
        wa           = wr_idx[ADDR_W-1:0];
        wd           = top_reg;
        if (go) begin
            if (latched_reg && cmd.op != CMD_END) begin
                cmd_pop = 1'b1;
            end else begin
                case (cmd.op)
                    CMD_EMIT: begin
                        load    = 1'b1;
                        o_char  = cmd.ch;
                        o_last  = 1'b1;
                        cmd_pop = 1'b1;
                    end
                    CMD_OPEN, CMD_OP: begin
                        if (cmd.op == CMD_OP && cnt_nz && top_prec >= cmd.prec) begin
                            // pop and emit; last if the push comes next
                            load     = 1'b1;
                            o_char   = top_reg;
                            o_last   = !(cnt_ge2 && below_prec >= cmd.prec);
                            cnt_next = cnt_reg - CNT_W'(1);
                            top_next = below_reg;
                        end else if (full) begin
                            load         = 1'b1;
                            o_kind       = KIND_ERR;
                            o_code       = ERR_OVER;
                            o_last       = 1'b1;
                            latched_next = 1'b1;
                            cmd_pop      = 1'b1;
                        end else begin
                            we       = cnt_nz;
                            top_next = cmd.ch;
                            cnt_next = cnt_reg + CNT_W'(1);
                            cmd_pop  = 1'b1;
                        end
                    end
                    CMD_CLOSE: begin
                        if (!cnt_nz) begin
                            load         = 1'b1;
                            o_kind       = KIND_ERR;
                            o_code       = ERR_CLOSE;
                            o_last       = 1'b1;
                            latched_next = 1'b1;
                            cmd_pop      = 1'b1;
                        end else if (top_reg == CH_LPAREN) begin
                            cnt_next = cnt_reg - CNT_W'(1);
                            top_next = below_reg;
                            cmd_pop  = 1'b1;
                        end else begin
                            // last if the matching paren lies just below
                            load     = 1'b1;
                            o_char   = top_reg;
                            o_last   = cnt_ge2 && (below_reg == CH_LPAREN);
                            cnt_next = cnt_reg - CNT_W'(1);
                            top_next = below_reg;
                        end
                    end
                    CMD_END: begin
                        load = 1'b1;
                        if (!latched_reg && cnt_nz && top_reg != CH_LPAREN) begin
                            o_char   = top_reg;
                            cnt_next = cnt_reg - CNT_W'(1);
                            top_next = below_reg;
                        end else begin
                            if (!latched_reg && cnt_nz) begin
                                o_kind = KIND_ERR;
                                o_code = ERR_OPEN;
                            end else begin
                                o_kind = KIND_DONE;
                            end
                            o_last       = 1'b1;
                            cnt_next     = '0;
                            latched_next = 1'b0;
                            cmd_pop      = 1'b1;
                        end
                    end
                    default: begin
                        cmd_pop = 1'b1;
                    end
                endcase
            end
        end
    end

    // Prefetch the entry under the next top
    assign rd_idx = cnt_next - CNT_W'(2);
    assign ra     = rd_idx[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (we) begin
            stk_mem[wa] <= wd;
        end
        if (we && wa == ra) begin
            below_reg <= wd;
        end else begin
            below_reg <= stk_mem[ra];
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            latched_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            latched_reg <= latched_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (load) begin
            char_reg <= o_char;
            kind_reg <= o_kind;
            code_reg <= o_code;
            last_reg <= o_last;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_char_out         = char_reg;
    assign m_kind             = kind_reg;
    assign m_error_code       = code_reg;
    assign m_last             = last_reg;
    assign stk_status.depth   = cnt_reg;
    assign stk_status.latched = latched_reg;

endmodule

[dv/infix_to_postfix_converter_test.sv]
module infix_to_postfix_converter_test;
    import itp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 285;
    localparam int MAX_NESTING    = 2;
    localparam logic [1:0] CODE_NONE = 2'd0;

    // One postfix result as it leaves the block
    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] kind;
        logic [1:0] code;
        logic       last;
    } postfix_res_t;

    // How a directed row is checked
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_RESULT,
        ONE_RESULT
    } row_chk_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        row_chk_t   chk;
        logic [7:0] x_ch;
        logic [1:0] x_kind;
        logic [1:0] x_code;
    } dir_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_in;
    logic       s_is_end;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_char_out;
    logic [1:0] m_kind;
    logic [1:0] m_error_code;
    logic       m_last;

    // Directed stimulus: an unmatched close, then every operator and the odd bytes, ending on an unmatched open
    dir_row_t dir_rows [25] = '{
        '{"a",       1'b0, ONE_RESULT, "a",   KIND_CHAR, CODE_NONE},
        '{CH_RPAREN, 1'b0, ONE_RESULT, 8'h00, KIND_ERR,  ERR_CLOSE},
        '{CH_PLUS,   1'b0, NO_RESULT,  8'h00, KIND_CHAR, CODE_NONE},
        '{8'h00,     1'b1, ONE_RESULT, 8'h00, KIND_DONE, CODE_NONE},
        '{CH_LPAREN, 1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{"1",       1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{CH_MINUS,  1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{"2",       1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{CH_SLASH,  1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{"3",       1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{CH_RPAREN, 1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{CH_CARET,  1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{"z",       1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{CH_CARET,  1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{CH_SPACE,  1'b0, NO_RESULT,  8'h00, KIND_CHAR, CODE_NONE},
        '{CH_TAB,    1'b0, NO_RESULT,  8'h00, KIND_CHAR, CODE_NONE},
        '{CH_CR,     1'b0, NO_RESULT,  8'h00, KIND_CHAR, CODE_NONE},
        '{CH_STAR,   1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{8'h00,     1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{8'hFF,     1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{CH_LPAREN, 1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{"#",       1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{8'hFF,     1'b1, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{CH_LPAREN, 1'b0, BY_MODEL,   8'h00, KIND_CHAR, CODE_NONE},
        '{8'h00,     1'b1, ONE_RESULT, 8'h00, KIND_ERR,  ERR_OPEN}
    };

    // Shadow operator stack
    logic [7:0]   op_mem [STACK_DEPTH];
    int           op_cnt;
    bit           err_hold;
    postfix_res_t step_out [$];
    postfix_res_t postfix_q [$];

    int n_items;
    int n_live;
    int n_results;
    int n_fail;
    int n_nesting;
    int err_seen [3];

    infix_to_postfix_converter u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .s_is_end     (s_is_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_out   (m_char_out),
        .m_kind       (m_kind),
        .m_error_code (m_error_code),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int rank_of(input logic [7:0] c);
        case (c)
            CH_PLUS, CH_MINUS: return 1;
            CH_STAR, CH_SLASH: return 2;
            CH_CARET:          return 3;
            default:           return 0;
        endcase
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_operand(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // Advance the shadow stack by one input transfer; results land in step_out.
    // Returns 0 when the byte is skipped or swallowed by a latched error.
    function automatic bit shunt_char(input logic [7:0] c, input logic fin);
        logic [7:0] top;
        bit         open_left;
        step_out.delete();
        if (fin) begin
            // flush, stopping at a leftover open paren
            open_left = 1'b0;
            while (!err_hold && op_cnt > 0 && !open_left) begin
                op_cnt--;
                top = op_mem[op_cnt];
                if (top == CH_LPAREN) begin
                    open_left = 1'b1;
                end else begin
                    step_out.push_back('{top, KIND_CHAR, CODE_NONE, 1'b0});
                end
            end
            op_cnt   = 0;
            err_hold = 1'b0;
            if (open_left) begin
                step_out.push_back('{8'h00, KIND_ERR, ERR_OPEN, 1'b0});
            end else begin
                step_out.push_back('{8'h00, KIND_DONE, CODE_NONE, 1'b0});
            end
        end else if (err_hold || is_blank(c)) begin
            return 1'b0;
        end else if (is_operand(c)) begin
            step_out.push_back('{c, KIND_CHAR, CODE_NONE, 1'b0});
        end else if (c == CH_RPAREN) begin
            while (op_cnt > 0 && op_mem[op_cnt-1] != CH_LPAREN) begin
                op_cnt--;
                step_out.push_back('{op_mem[op_cnt], KIND_CHAR, CODE_NONE, 1'b0});
            end
            if (op_cnt == 0) begin
                step_out.push_back('{8'h00, KIND_ERR, ERR_CLOSE, 1'b0});
                err_hold = 1'b1;
            end else begin
                op_cnt--;
            end
        end else begin
            // open paren pushes straight away; every other byte pops by rank first
            if (c != CH_LPAREN) begin
                while (op_cnt > 0 && rank_of(op_mem[op_cnt-1]) >= rank_of(c)) begin
                    op_cnt--;
                    step_out.push_back('{op_mem[op_cnt], KIND_CHAR, CODE_NONE, 1'b0});
                end
            end
            if (op_cnt >= STACK_DEPTH) begin
                step_out.push_back('{8'h00, KIND_ERR, ERR_OVER, 1'b0});
                err_hold = 1'b1;
            end else begin
                op_mem[op_cnt] = c;
                op_cnt++;
            end
        end
        if (step_out.size() > 0) begin
            step_out[step_out.size()-1].last = 1'b1;
        end
        return 1'b1;
    endfunction

    // Geometric idle run: each further idle cycle comes with a chance of 32 in a hundred, none when calm
    function automatic int idle_run(input bit calm);
        int n;
        n = 0;
        if (!calm) begin
            while ($urandom_range(99) < 32) n++;
        end
        return n;
    endfunction

    function automatic logic [7:0] rand_operand();
        int r;
        r = $urandom_range(61);
        if (r < 10) return 8'("0" + r);
        if (r < 36) return 8'("A" + r - 10);
        return 8'("a" + r - 36);
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(5);
        if (r == 5) return CH_SPACE;
        return 8'(9 + r);
    endfunction

    // A stray paren or random byte to drop into an otherwise clean expression
    function automatic logic [7:0] rand_spoiler();
        case ($urandom_range(3))
            0:       return CH_RPAREN;
            1:       return CH_LPAREN;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offer one byte and wait for its transfer
    task automatic drive_item(input logic [7:0] c, input logic fin);
        int gap;
        gap = idle_run(n_items >= 140 && n_items < 200);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        s_is_end  <= fin;
        do @(posedge aclk); while (!s_ready);
        n_items++;
    endtask

    task automatic feed(input logic [7:0] c, input logic fin);
        drive_item(c, fin);
        if (shunt_char(c, fin)) n_live++;
        postfix_q = {postfix_q, step_out};
    endtask

    // Well-formed infix with random operands, operators, parens and blanks;
    // a broken one gets a stray byte dropped in somewhere
    task automatic send_expression(input bit broken);
        int depth;
        int k;
        int ntok;
        int bad_at;
        bit want_operand;
        depth        = 0;
        k            = 0;
        want_operand = 1'b1;
        ntok         = $urandom_range(12, 1);
        bad_at       = broken ? int'($urandom_range(ntok)) : -1;
        forever begin
            if ($urandom_range(99) < 12) feed(rand_blank(), 1'b0);
            if (k == bad_at) feed(rand_spoiler(), 1'b0);
            if (want_operand) begin
                if (k < ntok && depth < 6 && $urandom_range(99) < 25) begin
                    feed(CH_LPAREN, 1'b0);
                    depth++;
                end else begin
                    feed(rand_operand(), 1'b0);
                    want_operand = 1'b0;
                end
            end else if (depth > 0 && (k >= ntok || $urandom_range(99) < 30)) begin
                feed(CH_RPAREN, 1'b0);
                depth--;
            end else if (k >= ntok) begin
                break;
            end else begin
                feed(rand_operator(), 1'b0);
                want_operand = 1'b1;
            end
            k++;
        end
        // byte is a don't-care on end items
        feed(8'($urandom_range(255)), 1'b1);
    endtask

    // Deep paren nesting, runs into the stack limit most of the time
    task automatic send_nesting();
        repeat ($urandom_range(35, 30)) feed(CH_LPAREN, 1'b0);
        feed(rand_operator(), 1'b0);
        feed(rand_operand(), 1'b0);
        feed(8'h00, 1'b1);
        n_nesting++;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(8, 1)) feed(8'($urandom_range(255)), 1'b0);
        if ($urandom_range(1)) feed(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_fail++;
        end
    endfunction

    // Result checker
    always @(posedge aclk) begin
        postfix_res_t got;
        postfix_res_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_char_out, m_kind, m_error_code, m_last};
            n_results++;
            if (got.kind == KIND_ERR && got.code <= ERR_OVER) err_seen[got.code]++;
            if (postfix_q.size() == 0) begin
                $display("%0t: unexpected result transfer, char %h kind %0d code %0d last %0b",
                         $time, got.ch, got.kind, got.code, got.last);
                n_fail++;
            end else begin
                want = postfix_q.pop_front();
                check_field("char_out", want.ch, got.ch);
                check_field("kind", 8'(want.kind), 8'(got.kind));
                check_field("error_code", 8'(want.code), 8'(got.code));
                check_field("last", 8'(want.last), 8'(got.last));
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a calm stretch
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        m_ready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && n_results >= 60) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= (n_results >= 100 && n_results < 160) || ($urandom_range(99) >= 32);
            end
        end
    end

    // Watchdog on transfer activity
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus
    initial begin
        int r;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_char_in = 8'h00;
        s_is_end  = 1'b0;
        op_cnt    = 0;
        err_hold  = 1'b0;
        n_items   = 0;
        n_live    = 0;
        n_results = 0;
        n_fail    = 0;
        n_nesting = 0;
        foreach (err_seen[i]) err_seen[i] = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows
        foreach (dir_rows[i]) begin
            drive_item(dir_rows[i].ch, dir_rows[i].fin);
            void'(shunt_char(dir_rows[i].ch, dir_rows[i].fin));
            case (dir_rows[i].chk)
                BY_MODEL: begin
                    postfix_q = {postfix_q, step_out};
                end
                ONE_RESULT: begin
                    postfix_q.push_back('{dir_rows[i].x_ch, dir_rows[i].x_kind,
                                          dir_rows[i].x_code, 1'b1});
                end
                default: begin
                end
            endcase
        end

        // random part, mostly clean expressions
        n_live = 0;
        while (n_items < $size(dir_rows) + RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 70) begin
                send_expression(1'b0);
            end else if (r < 82) begin
                send_expression(1'b1);
            end else if (r < 92) begin
                send_noise();
            end else if (n_nesting < MAX_NESTING) begin
                send_nesting();
            end else begin
                send_expression(1'b0);
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (postfix_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Drove %0d input transfers (%0d live in the random part), checked %0d results.",
                 n_items, n_live, n_results);
        $display("Errors seen: %0d unmatched close, %0d unmatched open, %0d overflow;",
                 err_seen[ERR_CLOSE], err_seen[ERR_OPEN], err_seen[ERR_OVER]);
        $display("%0d deep nests.", n_nesting);
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
